[rtl/ppd_pkg.sv]
// Shared constants for the perfect power detector.
package ppd_pkg;

    localparam int DIGIT_BITS    = 16;
    localparam int BASE_BITS     = 32;
    localparam int EXP_BITS      = 6;
    localparam int OUT_DATA_BITS = ((BASE_BITS + EXP_BITS + 7) / 8) * 8;

endpackage

[rtl/ppd_lead.sv]
// Leading-one scanner: shifts the value left one bit a cycle until its MSB is set.
module ppd_lead #(
    parameter int VALUE_BITS = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_done,
    output logic [$clog2(VALUE_BITS)-1:0] o_lead
);

    localparam int LW = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic [VALUE_BITS-1:0] r_v;
    logic [LW-1:0]         r_pos;

    assign o_done = r_busy && r_v[VALUE_BITS-1];
    assign o_lead = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_pos <= LW'(VALUE_BITS - 1);
        end else if (r_busy && !r_v[VALUE_BITS-1]) begin
            r_v   <= r_v << 1;
            r_pos <= r_pos - 1'b1;
        end
    end

endmodule

[rtl/ppd_mul.sv]
// Digit-serial multiplier: one A x DIGIT_BITS partial product per cycle, MSB digit first.
module ppd_mul
    import ppd_pkg::*;
#(
    parameter int A_BITS = 63,
    parameter int B_BITS = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [A_BITS-1:0]     i_a,
    input  logic [B_BITS-1:0]     i_b,
    output logic                  o_done,
    output logic [A_BITS + ((B_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] o_prod
);

    localparam int ND = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BP = ND * DIGIT_BITS;
    localparam int PW = A_BITS + BP;
    localparam int QW = A_BITS + DIGIT_BITS;
    localparam int CW = $clog2(ND + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [A_BITS-1:0]     r_a;
    logic [BP-1:0]         r_b;
    logic [QW-1:0]         r_pp;
    logic [PW-1:0]         r_acc;
    logic [DIGIT_BITS-1:0] w_digit;

    assign w_digit = r_b[BP-1 -: DIGIT_BITS];
    assign o_done  = r_done;
    assign o_prod  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(ND));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(ND))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BP'(i_b);
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_pp  <= r_a * w_digit;
            r_b   <= r_b << DIGIT_BITS;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt != '0) begin
                r_acc <= (r_acc << DIGIT_BITS) + PW'(r_pp);
            end
        end
    end

endmodule

[rtl/perfect_power_detector_top.sv]
// Perfect power detector: sequencer with bisection over a shared digit-serial multiplier.
//
// Slave stream: one word carries the value to test in tdata bits [VALUE_BITS-1:0].
// Master stream: one result word per input word; tuser = found, tdata holds the
// base in [31:0] and the exponent in [37:32]; both are zero when not found.
// Exponents run from 2 up to the leading-one position of the value; for each, the
// base is bisected in [2, 2^(floor(top/e)+1)] and the first exact hit is returned.
// Values below 4 go straight from accept to the done state and are reported once the
// output register is free. Otherwise the leading-one scanner finds the leading one,
// then each bisection step runs up to e-1 multiplies on the digit-serial multiplier,
// which takes the base in ND 16-bit digits (3 at 63 bits).
// One value is in flight at a time; s_axis_tready is high only when the sequencer
// is idle. The result sits in an output register, so a stalled receiver does not
// stop the next value from being accepted; a second result waits until the first
// is taken. Reset clears the sequencer and the output valid.
module perfect_power_detector_top
    import ppd_pkg::*;
#(
    parameter int VALUE_BITS = 63
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // value
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]              m_axis_tdata,  // base, exponent
    output logic                                  m_axis_tuser   // found
);

    localparam int W   = VALUE_BITS;
    localparam int LW  = $clog2(W);
    localparam int EW  = LW + 1;
    localparam int BW  = (W - 1) / 2 + 2;
    localparam int ND  = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW  = W + ND * DIGIT_BITS;
    localparam int PAD = OUT_DATA_BITS - BASE_BITS - EXP_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEAD = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_MID  = 3'd3;
    localparam logic [2:0] S_BND  = 3'd4;
    localparam logic [2:0] S_POW  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]           r_state, n_state;
    logic                 r_ovalid, n_ovalid;
    logic                 r_ofound, n_ofound;
    logic [BASE_BITS-1:0] r_obase, n_obase;
    logic [EXP_BITS-1:0]  r_oexp, n_oexp;
    logic [W-1:0]         r_n, n_n;
    logic [LW-1:0]        r_top, n_top;
    logic [LW-1:0]        r_e, n_e;
    logic [LW-1:0]        r_q, n_q;
    logic [EW-1:0]        r_qe, n_qe;
    logic [LW-1:0]        r_k, n_k;
    logic [BW-1:0]        r_lo, n_lo;
    logic [BW-1:0]        r_hi, n_hi;
    logic [BW-1:0]        r_mid, n_mid;
    logic [W-1:0]         r_pow, n_pow;
    logic                 r_hit, n_hit;

    logic                 w_accept;
    logic [W-1:0]         w_value;
    logic                 w_lead_start;
    logic                 w_lead_done;
    logic [LW-1:0]        w_lead;
    logic                 w_mul_start;
    logic                 w_mul_done;
    logic [PW-1:0]        w_prod;
    logic [BW-1:0]        w_mid;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_value       = s_axis_tdata[W-1:0];
    assign w_lead_start  = w_accept && (w_value >= W'(4));
    assign w_mul_start   = (r_state == S_POW) && (r_k != r_e);
    assign w_mid         = r_lo + ((r_hi - r_lo) >> 1);

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tdata  = {{PAD{1'b0}}, r_oexp, r_obase};

    ppd_lead #(
        .VALUE_BITS(W)
    ) u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lead_start),
        .i_value (w_value),
        .o_done  (w_lead_done),
        .o_lead  (w_lead)
    );

    ppd_mul #(
        .A_BITS(W),
        .B_BITS(BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_pow),
        .i_b     (r_mid),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_ofound = r_ofound;
        n_obase  = r_obase;
        n_oexp   = r_oexp;
        n_n      = r_n;
        n_top    = r_top;
        n_e      = r_e;
        n_q      = r_q;
        n_qe     = r_qe;
        n_k      = r_k;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_pow    = r_pow;
        n_hit    = r_hit;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_n   = w_value;
                    n_hit = 1'b0;
                    if (w_value < W'(4)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LEAD;
                    end
                end
            end
            S_LEAD: begin
                if (w_lead_done) begin
                    n_top   = w_lead;
                    n_e     = LW'(2);
                    n_q     = w_lead >> 1;
                    n_qe    = {1'b0, w_lead[LW-1:1], 1'b0};
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_lo    = BW'(2);
                n_hi    = BW'(2) << r_q;
                n_state = S_MID;
            end
            S_MID: begin
                if (r_lo > r_hi) begin
                    if (r_e == r_top) begin
                        n_state = S_DONE;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_qe    = r_qe + EW'(r_q);
                        n_state = S_BND;
                    end
                end else begin
                    n_mid   = w_mid;
                    n_pow   = W'(w_mid);
                    n_k     = LW'(1);
                    n_state = S_POW;
                end
            end
            S_BND: begin
                if (r_qe > EW'(r_top)) begin
                    n_qe = r_qe - EW'(r_e);
                    n_q  = r_q - 1'b1;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_POW: begin
                if (r_k == r_e) begin
                    if (r_pow == r_n) begin
                        n_hit   = 1'b1;
                        n_state = S_DONE;
                    end else if (r_pow < r_n) begin
                        n_lo    = r_mid + 1'b1;
                        n_state = S_MID;
                    end else begin
                        n_hi    = r_mid - 1'b1;
                        n_state = S_MID;
                    end
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    if (w_prod > PW'(r_n)) begin
                        n_hi    = r_mid - 1'b1;
                        n_state = S_MID;
                    end else begin
                        n_pow   = w_prod[W-1:0];
                        n_k     = r_k + 1'b1;
                        n_state = S_POW;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_hit;
                    n_obase  = r_hit ? BASE_BITS'(r_mid) : '0;
                    n_oexp   = r_hit ? EXP_BITS'(r_e) : '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ofound <= n_ofound;
        r_obase  <= n_obase;
        r_oexp   <= n_oexp;
        r_n      <= n_n;
        r_top    <= n_top;
        r_e      <= n_e;
        r_q      <= n_q;
        r_qe     <= n_qe;
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_pow    <= n_pow;
        r_hit    <= n_hit;
    end

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside the multiply state");

    a_found_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofound) |-> (r_oexp >= EXP_BITS'(2)) && (r_obase >= BASE_BITS'(2)))
        else $error("reported power with exponent or base below two");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> (r_oexp == '0) && (r_obase == '0))
        else $error("miss reported with nonzero base or exponent");

    a_lo_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POW) |-> (r_mid >= BW'(2)) && (r_k <= r_e))
        else $error("bisection left its range");

endmodule

[verif/testbench.sv]
// Perfect power detector testbench: directed table, then random words checked by a predictor.
`timescale 1ns / 100ps

module testbench
    import ppd_pkg::*;
();

    localparam int          VALUE_BITS  = 63;
    localparam int          IN_BITS     = ((VALUE_BITS + 7) / 8) * 8;
    localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int          RANDOM_WORDS = 116;
    localparam int          IDLE_PCT    = 27;
    localparam longint      CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        logic                found;
        logic [BASE_BITS-1:0] base;
        logic [EXP_BITS-1:0]  exponent;
    } t_outcome;

    typedef struct {
        logic [63:0] word;
        bit          typed;
        t_outcome    outcome;
    } t_stim_row;

    typedef enum logic [1:0] {POW_BELOW, POW_EQUAL, POW_ABOVE} t_power_rel;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_valid = 1'b0;
    logic [IN_BITS-1:0]       s_data  = '0;
    logic                     m_ready = 1'b0;
    logic                     s_axis_tready;
    logic                     m_axis_tvalid;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tuser;

    t_outcome  pending_results[$];
    t_stim_row directed_rows[$];
    int        mismatches = 0;
    longint    cycles     = 0;
    bit        steady     = 1'b0;

    perfect_power_detector_top #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),         // value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),   // base, exponent
        .m_axis_tuser  (m_axis_tuser)    // found
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // smallest exponent, then bisect base in [2, isqrt(n)+1]
    function automatic t_outcome predict_power(input logic [63:0] word);
        t_outcome    res;
        logic [63:0] n, rem, root, probe, lo, hi, mid, prod;
        int unsigned top, expo, k;
        t_power_rel  rel;
        res = '0;
        n = word & VALUE_MASK;
        if (n < 4)
            return res;
        rem = n;
        top = 0;
        while (rem > 1) begin
            rem >>= 1;
            top++;
        end
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        for (expo = 2; expo <= top; expo++) begin
            lo = 2;
            hi = root + 1;
            while (lo <= hi) begin
                mid  = lo + (hi - lo) / 2;
                prod = 1;
                rel  = POW_BELOW;
                for (k = 0; k < expo; k++) begin
                    if (prod > n / mid) begin
                        rel = POW_ABOVE;
                        break;
                    end
                    prod = prod * mid;
                end
                if (rel != POW_ABOVE)
                    rel = (prod < n) ? POW_BELOW : ((prod == n) ? POW_EQUAL : POW_ABOVE);
                if (rel == POW_EQUAL) begin
                    res.found    = 1'b1;
                    res.base     = mid[BASE_BITS-1:0];
                    res.exponent = expo[EXP_BITS-1:0];
                    return res;
                end
                if (rel == POW_BELOW)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
        end
        return res;
    endfunction

    // powers with random base and exponent in 45% of words, some off by one, the rest raw values
    function automatic logic [63:0] random_value();
        logic [63:0] word, base;
        int unsigned pick, expo, span, width, tweak;
        pick = $urandom_range(99);
        if (pick < 45) begin
            expo  = ($urandom_range(9) == 0) ? $urandom_range(13, 62) : $urandom_range(2, 12);
            span  = 62 / expo;
            if (span < 2) begin
                base = 64'd2;
            end else begin
                width = $urandom_range(2, span);
                base  = 64'd2 + {$urandom, $urandom} % ((64'd1 << width) - 64'd2);
            end
            word = 64'd1;
            repeat (expo) word = word * base;
            tweak = $urandom_range(4);
            if (tweak == 0)
                word = word + 1;
            else if (tweak == 1)
                word = word - 1;
        end else begin
            if (pick < 85)
                width = $urandom_range(3, 20);
            else if (pick < 95)
                width = $urandom_range(21, 40);
            else
                width = VALUE_BITS;
            word = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
        end
        word[63] = $urandom_range(1);
        return word;
    endfunction

    task automatic add_row(input logic [63:0] word, input bit typed,
                           input logic found, input logic [63:0] base, input int expo);
        t_stim_row row;
        row.word    = word;
        row.typed   = typed;
        row.outcome = '{found, base[BASE_BITS-1:0], expo[EXP_BITS-1:0]};
        directed_rows.push_back(row);
    endtask

    task automatic offer_word(input logic [63:0] word, input bit typed, input t_outcome given);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(typed ? given : predict_power(word));
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: found %0b base %0d exponent %0d",
                       m_axis_tuser, m_axis_tdata[BASE_BITS-1:0],
                       m_axis_tdata[BASE_BITS +: EXP_BITS]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[BASE_BITS-1:0] !== want.base) begin
                    $error("base: expected %0d, got %0d", want.base,
                           m_axis_tdata[BASE_BITS-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[BASE_BITS +: EXP_BITS] !== want.exponent) begin
                    $error("exponent: expected %0d, got %0d", want.exponent,
                           m_axis_tdata[BASE_BITS +: EXP_BITS]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(64'd0, 1, 1'b0, 0, 0);
        add_row(64'd1, 1, 1'b0, 0, 0);
        add_row(64'd2, 1, 1'b0, 0, 0);
        add_row(64'd3, 1, 1'b0, 0, 0);
        add_row(64'd4, 1, 1'b1, 2, 2);
        add_row(64'd8, 1, 1'b1, 2, 3);
        add_row(64'd5, 0, 1'b0, 0, 0);
        add_row(64'd9, 0, 1'b0, 0, 0);
        add_row(64'd16, 0, 1'b0, 0, 0);
        add_row(64'd27, 0, 1'b0, 0, 0);
        add_row(64'd32, 0, 1'b0, 0, 0);
        add_row(64'd128, 0, 1'b0, 0, 0);
        add_row(64'd1000000, 0, 1'b0, 0, 0);
        add_row(64'h8000_0000_0000_0000, 1, 1'b0, 0, 0);
        add_row(64'h8000_0000_0000_0004, 1, 1'b1, 2, 2);
        add_row(64'h4000_0000_0000_0000, 1, 1'b1, 64'd2147483648, 2);
        add_row(64'h2000_0000_0000_0000, 1, 1'b1, 2, 61);
        add_row(64'd9223372030926249001, 1, 1'b1, 64'd3037000499, 2);
        add_row(64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0, 0, 0);
        add_row(64'h3FFF_FFFF_FFFF_FFFF, 0, 1'b0, 0, 0);
        add_row(64'h4000_0000_0000_0001, 0, 1'b0, 0, 0);
        add_row(64'd4052555153018976267, 0, 1'b0, 0, 0);
        add_row(64'd79792266297612001, 0, 1'b0, 0, 0);
        add_row(64'd437893890380859375, 0, 1'b0, 0, 0);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].outcome);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            steady = (k >= 60 && k < 95);
            offer_word(random_value(), 1'b0, '0);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/ppd_pkg.sv
rtl/ppd_lead.sv
rtl/ppd_mul.sv
rtl/perfect_power_detector_top.sv
verif/testbench.sv
